/* rtl/ifd_pkg.sv */
// Package for the inertial frame decoder: frame layout constants and types.
// No dependencies; imported by the byte interface and the core.
`timescale 1ns / 1ps
package ifd_pkg;

  localparam int unsigned POS_W       = 5;
  localparam int unsigned DATA_BYTES  = 20;
  localparam int unsigned FRAME_BYTES = 21;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [7:0]       byte_t;

  localparam pos_t  POS_CHECKSUM = pos_t'(DATA_BYTES);
  localparam pos_t  POS_IDLE     = pos_t'(FRAME_BYTES);
  localparam byte_t HEAD0        = 8'hAA;
  localparam byte_t HEAD1        = 8'h55;

endpackage

/* rtl/ifd_stream_if.sv */
// Valid/ready channel interfaces for the byte input and the decoded frame output.
// Depends on ifd_pkg for the byte type.
`timescale 1ns / 1ps
interface ifd_byte_if;
  import ifd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;
  logic  block_start;

  modport source (output valid, output rx_byte, output block_start, input ready);
  modport sink   (input valid, input rx_byte, input block_start, output ready);
endinterface

interface ifd_frame_if;
  logic               valid;
  logic               ready;
  logic               frame_ok;
  logic        [31:0] sample_count;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic        [15:0] temperature;

  modport source (output valid, output frame_ok, output sample_count,
                  output gyro_x, output gyro_y, output gyro_z,
                  output accel_x, output accel_y, output accel_z,
                  output temperature, input ready);
  modport sink   (input valid, input frame_ok, input sample_count,
                  input gyro_x, input gyro_y, input gyro_z,
                  input accel_x, input accel_y, input accel_z,
                  input temperature, output ready);
endinterface

/* rtl/imu_frame_decoder_core.sv */
// A result beat is registered in the output register once the checksum byte has
// passed the input register. Throughput: one input beat per cycle; the input
// register only waits while a finished result sits unaccepted in the output
// register and the byte it holds is a checksum byte. Synchronous active-low reset
// leaves the decoder idle, ignoring bytes until a block start; the 20-byte frame store is not cleared.
// Depends on ifd_pkg and the channel interfaces in ifd_stream_if.sv.
`timescale 1ns / 1ps
module imu_frame_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  ifd_byte_if.sink    in_bus,
  ifd_frame_if.source out_bus
);
  import ifd_pkg::*;

  logic  in_vld_r, in_vld_nxt;
  byte_t in_byte_r;
  logic  in_start_r;

  pos_t  pos_r, pos_nxt;
  byte_t sum_r, sum_nxt;
  byte_t store_r [DATA_BYTES];

  logic  out_vld_r, out_vld_nxt;
  logic  ok_r;
  logic  [31:0] count_r;
  logic  [15:0] gx_r, gy_r, gz_r, ax_r, ay_r, az_r, temp_r;

  pos_t  eff_pos;
  logic  is_data, is_chk, out_free, take, ok;

  assign eff_pos  = in_start_r ? '0 : pos_r;
  assign is_data  = eff_pos < POS_CHECKSUM;
  assign is_chk   = eff_pos == POS_CHECKSUM;
  assign out_free = !out_vld_r || out_bus.ready;
  assign take     = in_vld_r && (!is_chk || out_free);
  assign ok       = (store_r[0] == HEAD0) && (store_r[1] == HEAD1) && (sum_r == in_byte_r);

  assign in_bus.ready = !in_vld_r || !is_chk || out_free;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    pos_nxt     = pos_r;
    sum_nxt     = sum_r;
    out_vld_nxt = out_vld_r && !out_bus.ready;
    if (take) begin
      in_vld_nxt = 1'b0;
      if (is_data) begin
        pos_nxt = eff_pos + pos_t'(1);
        sum_nxt = (eff_pos == '0) ? in_byte_r : byte_t'(sum_r + in_byte_r);
      end else if (is_chk) begin
        pos_nxt     = POS_IDLE;
        out_vld_nxt = 1'b1;
      end
    end
    if (in_bus.valid && in_bus.ready) begin
      in_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      pos_r     <= POS_IDLE;
      sum_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      pos_r     <= pos_nxt;
      sum_r     <= sum_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_byte_r  <= in_bus.rx_byte;
      in_start_r <= in_bus.block_start;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DATA_BYTES; i++) begin
      if (take && is_data && (eff_pos == pos_t'(i))) begin
        store_r[i] <= in_byte_r;
      end
    end
  end

  // A bad frame reports all fields as zero.
  always_ff @(posedge clk) begin
    if (take && is_chk) begin
      ok_r    <= ok;
      count_r <= ok ? {store_r[5], store_r[4], store_r[3], store_r[2]} : '0;
      gx_r    <= ok ? {store_r[7], store_r[6]} : '0;
      gy_r    <= ok ? {store_r[9], store_r[8]} : '0;
      gz_r    <= ok ? {store_r[11], store_r[10]} : '0;
      ax_r    <= ok ? {store_r[13], store_r[12]} : '0;
      ay_r    <= ok ? {store_r[15], store_r[14]} : '0;
      az_r    <= ok ? {store_r[17], store_r[16]} : '0;
      temp_r  <= ok ? {store_r[19], store_r[18]} : '0;
    end
  end

  assign out_bus.valid        = out_vld_r;
  assign out_bus.frame_ok     = ok_r;
  assign out_bus.sample_count = count_r;
  assign out_bus.gyro_x       = $signed(gx_r);
  assign out_bus.gyro_y       = $signed(gy_r);
  assign out_bus.gyro_z       = $signed(gz_r);
  assign out_bus.accel_x      = $signed(ax_r);
  assign out_bus.accel_y      = $signed(ay_r);
  assign out_bus.accel_z      = $signed(az_r);
  assign out_bus.temperature  = temp_r;

endmodule

/* rtl/ifd_checker.sv */
// Port-level checks for the inertial frame decoder core, attached by bind.
// Depends only on the core's channel signals.
`timescale 1ns / 1ps
module ifd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        frame_ok,
  input logic [31:0] sample_count,
  input logic [15:0] gyro_x,
  input logic [15:0] gyro_y,
  input logic [15:0] gyro_z,
  input logic [15:0] accel_x,
  input logic [15:0] accel_y,
  input logic [15:0] accel_z,
  input logic [15:0] temperature
);

  logic [144:0] payload;
  assign payload = {frame_ok, sample_count, gyro_x, gyro_y, gyro_z,
                    accel_x, accel_y, accel_z, temperature};

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(payload))
    else $error("result changed while stalled");

  // A rejected frame carries only zero fields.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !frame_ok |-> sample_count == 32'd0 && gyro_x == 16'd0 &&
      gyro_y == 16'd0 && gyro_z == 16'd0 && accel_x == 16'd0 &&
      accel_y == 16'd0 && accel_z == 16'd0 && temperature == 16'd0)
    else $error("rejected frame has nonzero fields");

  // Input back-pressure only arises from a stalled result.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // A new result must follow an accepted input beat, which the core passes through its input and output registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching input beat");

endmodule

bind imu_frame_decoder_core ifd_checker u_ifd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_bus.valid),
  .in_ready     (in_bus.ready),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .frame_ok     (out_bus.frame_ok),
  .sample_count (out_bus.sample_count),
  .gyro_x       (out_bus.gyro_x),
  .gyro_y       (out_bus.gyro_y),
  .gyro_z       (out_bus.gyro_z),
  .accel_x      (out_bus.accel_x),
  .accel_y      (out_bus.accel_y),
  .accel_z      (out_bus.accel_z),
  .temperature  (out_bus.temperature)
);
